[rtl/stxep_pkg.sv]
// Shared types and constants for the transaction envelope parser.
package stxep_pkg;

  // Longest accepted serialized transaction, and the cap on counts and lengths.
  localparam int unsigned MaxTxBytes = 1048576;
  // Width of byte counts, offsets and lengths.
  localparam int unsigned LenW = 21;

  // Compact-size prefix codes.
  localparam logic [7:0] CsPrefix16 = 8'd253;
  localparam logic [7:0] CsPrefix32 = 8'd254;
  localparam logic [7:0] CsPrefix64 = 8'd255;

  // Fixed field sizes skipped inside inputs and outputs.
  localparam logic [LenW-1:0] InPrefixBytes = LenW'(36);
  localparam logic [LenW-1:0] InSeqBytes    = LenW'(4);
  localparam logic [LenW-1:0] OutValueBytes = LenW'(8);

  typedef enum logic [3:0] {
    PhVersion  = 4'd0,
    PhInCount  = 4'd1,
    PhInPrefix = 4'd2,
    PhInScrLen = 4'd3,
    PhInScript = 4'd4,
    PhInSeq    = 4'd5,
    PhOutCount = 4'd6,
    PhOutValue = 4'd7,
    PhOutScrLen = 4'd8,
    PhOutScript = 4'd9,
    PhLock     = 4'd10,
    PhPayLen   = 4'd11,
    PhPayload  = 4'd12,
    PhDone     = 4'd13
  } phase_e;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } stxep_in_t;

  typedef struct packed {
    logic            valid_res;
    logic [15:0]     version;
    logic [15:0]     tx_type;
    logic [31:0]     lock_time;
    logic [LenW-1:0] payload_offset;
    logic [LenW-1:0] payload_length;
    logic [LenW-1:0] total_length;
  } stxep_out_t;

endpackage

[rtl/stxep_parser.sv]
// Parse state and per-byte update; emits one result on the last byte.
module stxep_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  stxep_pkg::stxep_in_t in_i,
  output logic                 res_valid_o,
  output stxep_pkg::stxep_out_t res_o
);

  localparam int unsigned LenW = stxep_pkg::LenW;

  stxep_pkg::phase_e phase_q, phase_d;
  logic [2:0]      idx_q, idx_d;
  logic            pfx4_q, pfx4_d;
  logic [31:0]     acc_q, acc_d;
  logic [LenW-1:0] entries_q, entries_d;
  logic [LenW-1:0] skip_q, skip_d;
  logic [LenW-1:0] offset_q, offset_d;
  logic [31:0]     ver_q, ver_d;
  logic [31:0]     lock_q, lock_d;
  logic [LenW-1:0] pstart_q, pstart_d;
  logic [LenW-1:0] psize_q, psize_d;
  logic            err_q, err_d;

  logic [7:0]      b;
  logic [1:0]      lane;
  logic [31:0]     acc_w;
  logic            c_ready;
  logic            c_bad;
  logic [31:0]     c_val;
  logic [LenW-1:0] v;
  logic [LenW-1:0] sk_dec;
  logic [LenW-1:0] ent_dec;
  logic            ok;
  logic            typed;

  assign b = in_i.tx_byte;

  // Compact-size decode of the current byte.
  always_comb begin
    lane    = idx_q[1:0] - 2'd1;
    acc_w   = acc_q;
    acc_w[{lane, 3'b000} +: 8] = b;
    c_ready = 1'b0;
    c_bad   = 1'b0;
    c_val   = 32'd0;
    if (idx_q == 3'd0) begin
      if (b < stxep_pkg::CsPrefix16) begin
        c_ready = 1'b1;
        c_val   = {24'd0, b};
      end else if (b == stxep_pkg::CsPrefix64) begin
        // 8-byte form always exceeds the length cap: fail at once
        c_ready = 1'b1;
        c_bad   = 1'b1;
      end
    end else if (idx_q == (pfx4_q ? 3'd4 : 3'd2)) begin
      c_ready = 1'b1;
      c_val   = acc_w;
      c_bad   = pfx4_q ? (acc_w <= 32'h0000_ffff) : (acc_w < 32'd253);
    end
    if (c_val > 32'(stxep_pkg::MaxTxBytes)) begin
      c_bad = 1'b1;
    end
    v = c_val[LenW-1:0];
  end

  // Next-state logic for one byte.
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    pfx4_d    = pfx4_q;
    acc_d     = acc_q;
    entries_d = entries_q;
    skip_d    = skip_q;
    offset_d  = offset_q;
    ver_d     = ver_q;
    lock_d    = lock_q;
    pstart_d  = pstart_q;
    psize_d   = psize_q;
    err_d     = err_q;
    sk_dec    = (skip_q != '0) ? skip_q - LenW'(1) : skip_q;
    ent_dec   = entries_q - LenW'(1);

    if (!err_q) begin
      if (offset_q >= LenW'(stxep_pkg::MaxTxBytes)) begin
        err_d = 1'b1;
      end else begin
        offset_d = offset_q + LenW'(1);
        unique case (phase_q)
          stxep_pkg::PhVersion, stxep_pkg::PhLock: begin
            if (phase_q == stxep_pkg::PhVersion) begin
              ver_d[{idx_q[1:0], 3'b000} +: 8] = b;
            end else begin
              lock_d[{idx_q[1:0], 3'b000} +: 8] = b;
            end
            if (idx_q[1:0] != 2'd3) begin
              idx_d = idx_q + 3'd1;
            end else begin
              idx_d = 3'd0;
              if (phase_q == stxep_pkg::PhVersion) begin
                phase_d = stxep_pkg::PhInCount;
              end else if (ver_q[31:16] != 16'd0) begin
                phase_d = stxep_pkg::PhPayLen;
              end else begin
                phase_d = stxep_pkg::PhDone;
              end
            end
          end
          stxep_pkg::PhInCount, stxep_pkg::PhInScrLen, stxep_pkg::PhOutCount,
          stxep_pkg::PhOutScrLen, stxep_pkg::PhPayLen: begin
            if (!c_ready) begin
              // still collecting prefix bytes
              if (idx_q == 3'd0) begin
                idx_d  = 3'd1;
                pfx4_d = (b == stxep_pkg::CsPrefix32);
                acc_d  = 32'd0;
              end else begin
                idx_d = idx_q + 3'd1;
                acc_d = acc_w;
              end
            end else begin
              idx_d = 3'd0;
              if (c_bad) begin
                err_d = 1'b1;
              end else begin
                case (phase_q)
                  stxep_pkg::PhInCount: begin
                    entries_d = v;
                    if (v == '0) begin
                      phase_d = stxep_pkg::PhOutCount;
                    end else begin
                      phase_d = stxep_pkg::PhInPrefix;
                      skip_d  = stxep_pkg::InPrefixBytes;
                    end
                  end
                  stxep_pkg::PhInScrLen: begin
                    if (v == '0) begin
                      phase_d = stxep_pkg::PhInSeq;
                      skip_d  = stxep_pkg::InSeqBytes;
                    end else begin
                      phase_d = stxep_pkg::PhInScript;
                      skip_d  = v;
                    end
                  end
                  stxep_pkg::PhOutCount: begin
                    entries_d = v;
                    if (v == '0) begin
                      phase_d = stxep_pkg::PhLock;
                    end else begin
                      phase_d = stxep_pkg::PhOutValue;
                      skip_d  = stxep_pkg::OutValueBytes;
                    end
                  end
                  stxep_pkg::PhOutScrLen: begin
                    if (v == '0) begin
                      entries_d = ent_dec;
                      if (ent_dec == '0) begin
                        phase_d = stxep_pkg::PhLock;
                      end else begin
                        phase_d = stxep_pkg::PhOutValue;
                        skip_d  = stxep_pkg::OutValueBytes;
                      end
                    end else begin
                      phase_d = stxep_pkg::PhOutScript;
                      skip_d  = v;
                    end
                  end
                  default: begin
                    pstart_d = offset_q + LenW'(1);
                    psize_d  = v;
                    if (v == '0) begin
                      phase_d = stxep_pkg::PhDone;
                    end else begin
                      phase_d = stxep_pkg::PhPayload;
                      skip_d  = v;
                    end
                  end
                endcase
              end
            end
          end
          stxep_pkg::PhInPrefix, stxep_pkg::PhInScript, stxep_pkg::PhInSeq,
          stxep_pkg::PhOutValue, stxep_pkg::PhOutScript, stxep_pkg::PhPayload: begin
            skip_d = sk_dec;
            if (sk_dec == '0) begin
              case (phase_q)
                stxep_pkg::PhInPrefix: phase_d = stxep_pkg::PhInScrLen;
                stxep_pkg::PhInScript: begin
                  phase_d = stxep_pkg::PhInSeq;
                  skip_d  = stxep_pkg::InSeqBytes;
                end
                stxep_pkg::PhInSeq: begin
                  entries_d = ent_dec;
                  if (ent_dec == '0) begin
                    phase_d = stxep_pkg::PhOutCount;
                  end else begin
                    phase_d = stxep_pkg::PhInPrefix;
                    skip_d  = stxep_pkg::InPrefixBytes;
                  end
                end
                stxep_pkg::PhOutValue: phase_d = stxep_pkg::PhOutScrLen;
                stxep_pkg::PhOutScript: begin
                  entries_d = ent_dec;
                  if (ent_dec == '0) begin
                    phase_d = stxep_pkg::PhLock;
                  end else begin
                    phase_d = stxep_pkg::PhOutValue;
                    skip_d  = stxep_pkg::OutValueBytes;
                  end
                end
                default: phase_d = stxep_pkg::PhDone;
              endcase
            end
          end
          default: begin
            // byte after a complete envelope: overrun
            err_d = 1'b1;
          end
        endcase
      end
    end
  end

  // Result built from the state after this byte.
  always_comb begin
    ok          = !err_d && (phase_d == stxep_pkg::PhDone);
    typed       = ok && (ver_d[31:16] != 16'd0);
    res_valid_o = step_i && in_i.last_byte;
    res_o.valid_res      = ok;
    res_o.version        = ok ? ver_d[15:0] : 16'd0;
    res_o.tx_type        = ok ? ver_d[31:16] : 16'd0;
    res_o.lock_time      = ok ? lock_d : 32'd0;
    res_o.payload_offset = typed ? pstart_d : '0;
    res_o.payload_length = typed ? psize_d : '0;
    res_o.total_length   = ok ? offset_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= stxep_pkg::PhVersion;
      idx_q     <= '0;
      pfx4_q    <= 1'b0;
      acc_q     <= '0;
      entries_q <= '0;
      skip_q    <= '0;
      offset_q  <= '0;
      ver_q     <= '0;
      lock_q    <= '0;
      pstart_q  <= '0;
      psize_q   <= '0;
      err_q     <= 1'b0;
    end else if (step_i) begin
      if (in_i.last_byte) begin
        // start over for the next transaction
        phase_q   <= stxep_pkg::PhVersion;
        idx_q     <= '0;
        pfx4_q    <= 1'b0;
        acc_q     <= '0;
        entries_q <= '0;
        skip_q    <= '0;
        offset_q  <= '0;
        ver_q     <= '0;
        lock_q    <= '0;
        pstart_q  <= '0;
        psize_q   <= '0;
        err_q     <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        idx_q     <= idx_d;
        pfx4_q    <= pfx4_d;
        acc_q     <= acc_d;
        entries_q <= entries_d;
        skip_q    <= skip_d;
        offset_q  <= offset_d;
        ver_q     <= ver_d;
        lock_q    <= lock_d;
        pstart_q  <= pstart_d;
        psize_q   <= psize_d;
        err_q     <= err_d;
      end
    end
  end

endmodule

[rtl/stxep_result_reg.sv]
// Output register holding one finished result until it is taken.
module stxep_result_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  stxep_pkg::stxep_out_t res_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output stxep_pkg::stxep_out_t out_o
);

  logic                  valid_q, valid_d;
  stxep_pkg::stxep_out_t data_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

endmodule

[rtl/special_tx_envelope_parser_core.sv]
// Top level of the streaming transaction envelope parser.
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+--------------------------
//  in      | sink      | stxep_in_t   | in_valid_i / in_stall_o
//  out     | source    | stxep_out_t  | out_valid_o / out_stall_i
//
// One byte is taken per cycle unless a last byte waits on the output register.
// A byte is held in the input register, then the parser updates its state; on
// a last byte the result is loaded into the output register as the parser
// steps on that byte.
// Reset clears the parse state to the start of the version field.
// Only a last byte waits on a full, stalled output register; other bytes
// keep flowing while a result is pending.
module special_tx_envelope_parser_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stxep_pkg::stxep_in_t  in_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output stxep_pkg::stxep_out_t out_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i
);

  // Input register
  stxep_pkg::stxep_in_t  in_q;
  logic                  in_valid_q, in_valid_d;
  logic                  in_take;

  // Parser step and result path
  logic                  step;
  logic                  res_valid;
  stxep_pkg::stxep_out_t res;
  logic                  res_free;

  // A buffered byte advances unless it closes a transaction and the result
  // slot is still blocked.
  assign step       = in_valid_q && (!in_q.last_byte || res_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (step) begin
      in_valid_d = 1'b0;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i;
    end
  end

  stxep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_i        (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  stxep_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
